// ===== rtl/xcfr_pkg.sv =====
// Package with the shared types, codes and reset constants of the frame receiver.
package xcfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'h58;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST   = 8'd192;
    localparam logic [BYTE_W-1:0] CONTROL_CODE_RST = 8'hF2;
    localparam logic [BYTE_W-1:0] STATUS_CODE_RST  = 8'hF3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FUNC    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_CONTROL  = 3'd1,
        KIND_STATUS   = 3'd2,
        KIND_OTHER    = 3'd3,
        KIND_BAD_SUM  = 3'd4,
        KIND_OVERLONG = 3'd5
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE   = 2'd0,
        REG_MAX_LENGTH   = 2'd1,
        REG_CONTROL_CODE = 2'd2,
        REG_STATUS_CODE  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] max_length;
        logic [BYTE_W-1:0] control_code;
        logic [BYTE_W-1:0] status_code;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] function_code;
        logic [BYTE_W-1:0] frame_length;
    } result_t;

endpackage

// ===== rtl/xcfr_if.sv =====
// Stream interfaces for received bytes and for frame results.
interface xcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] function_code;
    logic [7:0] frame_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output function_code, output frame_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input function_code, input frame_length, output ready);
endinterface

// ===== rtl/xcfr_cfg_regs.sv =====
// Configuration register bank of the frame receiver.
module xcfr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xcfr_pkg::BYTE_W-1:0]    cfg_data,
    output xcfr_pkg::cfg_t                cfg
);
    import xcfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_START_BYTE:   cfg_next.start_byte   = cfg_data;
                REG_MAX_LENGTH:   cfg_next.max_length   = cfg_data;
                REG_CONTROL_CODE: cfg_next.control_code = cfg_data;
                REG_STATUS_CODE:  cfg_next.status_code  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte   <= START_BYTE_RST;
            cfg_reg.max_length   <= MAX_LENGTH_RST;
            cfg_reg.control_code <= CONTROL_CODE_RST;
            cfg_reg.status_code  <= STATUS_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/xcfr_parser.sv =====
// Frame parser: phase machine, running XOR check and result formation.
module xcfr_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  xcfr_pkg::cfg_t             cfg,
    input  logic                       step,
    input  logic [xcfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                       res_valid,
    output xcfr_pkg::result_t          res
);
    import xcfr_pkg::*;

    phase_t            phase_reg,    phase_next;
    logic [BYTE_W-1:0] function_reg, function_next;
    logic [BYTE_W-1:0] length_reg,   length_next;
    logic [BYTE_W-1:0] count_reg,    count_next;
    logic [BYTE_W-1:0] xor_reg,      xor_next;
    logic [BYTE_W-1:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    // Next state.
    always_comb
    begin
        phase_next    = phase_reg;
        function_next = function_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        unique case (phase_reg)
            PH_FUNC:
            begin
                function_next = rx_byte;
                xor_next      = rx_byte;
                phase_next    = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                xor_next    = xor_reg ^ rx_byte;
                count_next  = '0;
                if (rx_byte > cfg.max_length)
                    phase_next = PH_IDLE;
                else if (rx_byte == '0)
                    phase_next = PH_CHECK;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                xor_next   = xor_reg ^ rx_byte;
                count_next = count_inc;
                if (count_inc == length_reg)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = (rx_byte == cfg.start_byte) ? PH_FUNC : PH_IDLE;
            end
        endcase
    end

    // Result for the byte now presented.
    always_comb
    begin
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.data_byte     = '0;
        res.byte_index    = '0;
        res.function_code = function_reg;
        res.frame_length  = length_reg;
        unique case (phase_reg)
            PH_LEN:
            begin
                res.frame_length = rx_byte;
                if (rx_byte > cfg.max_length)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_OVERLONG;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid      = 1'b1;
                res.data_byte  = rx_byte;
                res.byte_index = count_reg;
            end
            PH_CHECK:
            begin
                res_valid = 1'b1;
                priority if (xor_reg != rx_byte)
                    res.kind = KIND_BAD_SUM;
                else if (function_reg == cfg.control_code)
                    res.kind = KIND_CONTROL;
                else if (function_reg == cfg.status_code)
                    res.kind = KIND_STATUS;
                else
                    res.kind = KIND_OTHER;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            function_reg <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            xor_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            function_reg <= function_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
        end
    end

    // An overlong length byte always yields exactly the overlong verdict.
    a_overlong: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_LEN && rx_byte > cfg.max_length)
        |-> (res_valid && res.kind == KIND_OVERLONG))
        else $error("overlong length did not give an overlong verdict");

    // Hunting and the function byte never produce a result.
    a_quiet_header: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_FUNC) |-> !res_valid)
        else $error("result produced during start or function byte");

    // Every payload beat advances the index by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_PAYLOAD)
        |=> (count_reg == $past(count_reg) + 8'd1))
        else $error("payload index did not advance by one");

    // The check byte always closes the frame.
    a_check_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_CHECK) |=> (phase_reg == PH_IDLE))
        else $error("parser did not return to idle after the check byte");

endmodule

// ===== rtl/xor_checked_frame_receiver.sv =====
// Top level of the XOR-checked frame receiver.
//
//  channel | direction | beat payload                                         | kind
//  --------+-----------+------------------------------------------------------+-----------
//  rx      | in        | rx_byte                                              | valid/ready
//  frame   | out       | kind, data_byte, byte_index, function_code,          | valid/ready
//          |           | frame_length                                         |
//  cfg     | in        | cfg_we, cfg_index, cfg_data (write only)             | strobe
//
// One received byte is taken per cycle unless frame.ready holds the block back.
// A byte is first captured in an input register; the parser then consumes it
// and, if it causes a result, that result is loaded into the output register,
// from which the result beat is offered.
// Reset (rst_n low, asynchronous) puts the parser in the hunting state, empties
// both registers and loads the register reset values.
// When the result register is full and frame.ready is low, the input register
// holds its byte and rx.ready drops only once the input register is also full;
// every byte, even one that causes no result, leaves the input register only
// when the output register is empty or is being emptied in the same cycle.
// Throughput is one byte per cycle while frame.ready stays high.
module xor_checked_frame_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    xcfr_byte_if.sink                     rx,
    xcfr_result_if.source                 frame,
    input  logic                          cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xcfr_pkg::BYTE_W-1:0]    cfg_data
);
    import xcfr_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              rx_take;
    logic              advance;
    logic              par_valid;
    result_t           par_res;

    xcfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The parser moves on whenever a byte is waiting and the output register
    // is free or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || frame.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    xcfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (par_valid),
        .res       (par_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = par_valid;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (rx_take)
            in_byte_reg <= rx.rx_byte;
        if (advance && par_valid)
            out_reg <= par_res;
    end

    assign frame.valid         = out_valid_reg;
    assign frame.kind          = out_reg.kind;
    assign frame.data_byte     = out_reg.data_byte;
    assign frame.byte_index    = out_reg.byte_index;
    assign frame.function_code = out_reg.function_code;
    assign frame.frame_length  = out_reg.frame_length;

endmodule

// ===== tb/sv/xor_checked_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the XOR-checked frame receiver: random framed traffic, scoreboard.
module xor_checked_frame_receiver_tb;
    import xcfr_pkg::*;

    localparam real CLK_PERIOD   = 4.0;
    localparam int  RESET_CYCLES = 5;
    // A byte passes the input and output registers before its result is offered; the
    // margin also lets header and idle bytes, which cause no result, clear the pipeline.
    localparam int  DRAIN_CYCLES = 8;
    // Long enough for both internal registers to fill and the input to stall.
    localparam int  HOLD_CYCLES  = 200;
    // Bound on the whole run; the watchdog stops the simulation once it is passed.
    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  PHASE_BEATS  = 40;
    localparam int  MAX_REPORTS  = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    xcfr_byte_if   rx_ch ();
    xcfr_result_if frame_ch ();

    xor_checked_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    // Bytes still to be offered on the receive channel, and the results that the
    // local parser model says must come back, oldest first.
    logic [7:0] rx_pending[$];
    result_t    awaited_results[$];

    // Register values as the block should hold them right now.
    cfg_t reg_shadow;

    // Parser model state.
    phase_t     p_phase;
    logic [7:0] p_function;
    logic [7:0] p_length;
    logic [7:0] p_count;
    logic [7:0] p_xor;

    // Flow control knobs shared between the stimulus, the two drivers and the hold-off.
    bit rx_taken       = 1'b0;
    bit src_idle_on    = 1'b1;
    bit pressure_go    = 1'b0;
    bit sink_hold      = 1'b0;
    int rx_gap_left    = 0;
    int src_calm_left  = 0;
    int snk_stall_left = 0;
    int snk_calm_left  = 0;

    // Bookkeeping for the summary and the verdict.
    int cycle_count   = 0;
    int fault_count   = 0;
    int frame_beats   = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int kind_tally[0:7];

    // ------------------------------------------------------------------------
    // Parser model. Every accepted beat is pushed through here in acceptance
    // order, so a register write between phases lands exactly where the block
    // sees it.
    // ------------------------------------------------------------------------
    task automatic expect_result(input kind_t k, input logic [7:0] d, input logic [7:0] idx);
        result_t r;
        r.kind          = k;
        r.data_byte     = d;
        r.byte_index    = idx;
        r.function_code = p_function;
        r.frame_length  = p_length;
        awaited_results.push_back(r);
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        kind_t verdict;
        case (p_phase)
            PH_FUNC: begin
                p_function = b;
                p_xor      = b;
                p_phase    = PH_LEN;
            end
            PH_LEN: begin
                p_length = b;
                p_xor    = p_xor ^ b;
                p_count  = 8'd0;
                // The length limit is sampled here; an overlong frame is reported
                // at once and whatever follows it is hunted through as noise.
                if (b > reg_shadow.max_length) begin
                    p_phase = PH_IDLE;
                    expect_result(KIND_OVERLONG, 8'd0, 8'd0);
                end else begin
                    p_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                expect_result(KIND_PAYLOAD, b, p_count);
                p_xor   = p_xor ^ b;
                p_count = p_count + 8'd1;
                if (p_count == p_length)
                    p_phase = PH_CHECK;
            end
            PH_CHECK: begin
                // Control wins over status when both codes are the same.
                if (p_xor != b)
                    verdict = KIND_BAD_SUM;
                else if (p_function == reg_shadow.control_code)
                    verdict = KIND_CONTROL;
                else if (p_function == reg_shadow.status_code)
                    verdict = KIND_STATUS;
                else
                    verdict = KIND_OTHER;
                p_phase = PH_IDLE;
                expect_result(verdict, 8'd0, 8'd0);
            end
            default: begin
                p_phase = (b == reg_shadow.start_byte) ? PH_FUNC : PH_IDLE;
            end
        endcase
    endtask

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random byte value.
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Receive side. Acceptance is sampled at the rising edge; the driver acts
    // on the falling edge and keeps valid high across back-to-back beats.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : rx_sample
        rx_taken <= rst_n && rx_ch.valid && rx_ch.ready;
        if (rst_n && rx_ch.valid && rx_ch.ready) begin
            parse_rx_byte(rx_ch.rx_byte);
            beats_taken++;
        end
    end

    always @(negedge clk) begin : rx_driver
        if (!rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (!rx_ch.valid || rx_taken) begin
            if (rx_gap_left > 0) begin
                rx_gap_left--;
                rx_ch.valid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
                rx_ch.rx_byte <= rx_pending.pop_front();
                rx_ch.valid   <= 1'b1;
                // A calm stretch sends beats back to back with no gaps at all.
                if (src_calm_left > 0) begin
                    src_calm_left--;
                    rx_gap_left = 0;
                end else begin
                    rx_gap_left = src_idle_on ? pick_gap() : 0;
                    if ($urandom_range(0, 49) == 0)
                        src_calm_left = $urandom_range(20, 80);
                end
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side. The ready driver stalls at random; the long hold-off below
    // overrides it while it runs.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : frame_ready_driver
        if (!rst_n || sink_hold) begin
            frame_ch.ready <= 1'b0;
        end else if (snk_stall_left > 0) begin
            snk_stall_left--;
            frame_ch.ready <= 1'b0;
        end else begin
            frame_ch.ready <= 1'b1;
            if (snk_calm_left > 0) begin
                snk_calm_left--;
            end else begin
                snk_stall_left = pick_gap();
                if ($urandom_range(0, 49) == 0)
                    snk_calm_left = $urandom_range(20, 80);
            end
        end
    end

    // The receiver refuses results for the length of the hold-off once the
    // stimulus asks for it, while the sender keeps offering bytes.
    always begin : receiver_hold_off
        @(posedge pressure_go);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    always @(posedge clk) begin : frame_check
        result_t got;
        result_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready) begin
            got.kind          = kind_t'(frame_ch.kind);
            got.data_byte     = frame_ch.data_byte;
            got.byte_index    = frame_ch.byte_index;
            got.function_code = frame_ch.function_code;
            got.frame_length  = frame_ch.frame_length;
            results_seen++;
            kind_tally[frame_ch.kind]++;
            if (awaited_results.size() == 0) begin
                flag_fault($sformatf(
                    "%0t: unexpected result kind %0d data %02h idx %0d func %02h len %0d",
                    $realtime, got.kind, got.data_byte, got.byte_index,
                    got.function_code, got.frame_length));
            end else begin
                want = awaited_results.pop_front();
                if (got !== want)
                    flag_fault({
                        $sformatf("%0t: expected kind %0d data %02h idx %0d func %02h len %0d",
                                  $realtime, want.kind, want.data_byte, want.byte_index,
                                  want.function_code, want.frame_length),
                        $sformatf(", got kind %0d data %02h idx %0d func %02h len %0d",
                                  got.kind, got.data_byte, got.byte_index,
                                  got.function_code, got.frame_length)});
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Cycle limit of %0d reached with %0d results outstanding.",
                     CYCLE_LIMIT, awaited_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Waits until every byte has been taken and every result has come back,
    // then lets the pipeline empty out. Returns just after a rising edge so the
    // caller can change queues and knobs without racing the drivers.
    task automatic wait_idle();
        while (rx_pending.size() != 0 || rx_ch.valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START_BYTE:   reg_shadow.start_byte   = val;
            REG_MAX_LENGTH:   reg_shadow.max_length   = val;
            REG_CONTROL_CODE: reg_shadow.control_code = val;
            REG_STATUS_CODE:  reg_shadow.status_code  = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] sb, input logic [7:0] ml,
                            input logic [7:0] cc, input logic [7:0] sc);
        write_reg(REG_START_BYTE, sb);
        write_reg(REG_MAX_LENGTH, ml);
        write_reg(REG_CONTROL_CODE, cc);
        write_reg(REG_STATUS_CODE, sc);
    endtask

    // Queues one whole frame. A negative fill gives random payload bytes;
    // otherwise every payload byte takes the fill value.
    task automatic queue_frame(input logic [7:0] fn, input logic [7:0] len,
                               input bit corrupt, input int fill);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        sum = fn ^ len;
        rx_pending.push_back(reg_shadow.start_byte);
        rx_pending.push_back(fn);
        rx_pending.push_back(len);
        for (k = 0; k < len; k++) begin
            if (fill < 0)
                b = rand_byte();
            else
                b = fill[7:0];
            rx_pending.push_back(b);
            sum = sum ^ b;
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        rx_pending.push_back(sum);
        frame_beats += len + 4;
    endtask

    // Mostly well-formed frames with random content, the rest line noise,
    // overlong headers and frames cut short.
    task automatic queue_random_traffic(input int budget);
        int         first;
        int         pick;
        int         len;
        int         top;
        int         cut;
        int         r;
        logic [7:0] fn;
        first = frame_beats;
        while (frame_beats - first < budget) begin
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 9);
            if (r < 3)
                fn = reg_shadow.control_code;
            else if (r < 6)
                fn = reg_shadow.status_code;
            else
                fn = rand_byte();
            top = (reg_shadow.max_length < 8'd8) ? int'(reg_shadow.max_length) : 8;
            if (pick < 8) begin
                // Noise between frames; it may well contain the start byte.
                repeat ($urandom_range(1, 3)) rx_pending.push_back(rand_byte());
            end else if (pick < 16 && reg_shadow.max_length != 8'hFF) begin
                len = $urandom_range(reg_shadow.max_length + 1, 255);
                rx_pending.push_back(reg_shadow.start_byte);
                rx_pending.push_back(fn);
                rx_pending.push_back(8'(len));
                frame_beats += 3;
                repeat ($urandom_range(0, 4)) rx_pending.push_back(rand_byte());
            end else if (pick < 22) begin
                // Frame cut short: the next frame's bytes get swallowed as its tail.
                len = $urandom_range(0, top);
                cut = $urandom_range(0, len);
                rx_pending.push_back(reg_shadow.start_byte);
                rx_pending.push_back(fn);
                rx_pending.push_back(8'(len));
                repeat (cut) rx_pending.push_back(rand_byte());
                frame_beats += 3 + cut;
            end else begin
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(0, reg_shadow.max_length);
                else
                    len = $urandom_range(0, top);
                queue_frame(fn, 8'(len), $urandom_range(0, 6) == 0, -1);
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] p0;
        logic [7:0] p1;
        int         n;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_START_BYTE;
        cfg_data          = 8'd0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = 8'd0;
        frame_ch.ready    = 1'b0;
        for (n = 0; n < 8; n++)
            kind_tally[n] = 0;

        reg_shadow.start_byte   = START_BYTE_RST;
        reg_shadow.max_length   = MAX_LENGTH_RST;
        reg_shadow.control_code = CONTROL_CODE_RST;
        reg_shadow.status_code  = STATUS_CODE_RST;
        p_phase    = PH_IDLE;
        p_function = 8'd0;
        p_length   = 8'd0;
        p_count    = 8'd0;
        p_xor      = 8'd0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks on the reset register values. Idle bytes that are not
        // the start byte must be ignored.
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'hA7);
        frame_beats += 3;
        // Zero length goes straight to the check byte; a good control frame.
        queue_frame(CONTROL_CODE_RST, 8'd0, 1'b0, -1);
        // One all-ones payload byte in a good status frame.
        queue_frame(STATUS_CODE_RST, 8'd1, 1'b0, 8'hFF);
        // All-zero payload and function byte with a broken check byte.
        queue_frame(8'h00, 8'd2, 1'b1, 8'h00);
        // Just over the length limit: flagged at once, then the tail is noise.
        rx_pending.push_back(START_BYTE_RST);
        rx_pending.push_back(8'h11);
        rx_pending.push_back(MAX_LENGTH_RST + 8'd1);
        rx_pending.push_back(8'h3C);
        frame_beats += 4;
        wait_idle();

        // A register write in the middle of a frame: the control code is taken
        // at the check byte, so the new value must decide the class.
        rx_pending.push_back(START_BYTE_RST);
        rx_pending.push_back(8'h77);
        rx_pending.push_back(8'h02);
        wait_idle();
        write_reg(REG_CONTROL_CODE, 8'h77);
        p0 = 8'h80;
        p1 = 8'h01;
        rx_pending.push_back(p0);
        rx_pending.push_back(p1);
        rx_pending.push_back(8'h77 ^ 8'h02 ^ p0 ^ p1);
        frame_beats += 6;
        wait_idle();
        queue_random_traffic(PHASE_BEATS);

        // Lowest extremes: start byte zero and no payload allowed at all.
        set_regs(8'h00, 8'h00, 8'hFF, 8'h00);
        queue_frame(8'hFF, 8'd0, 1'b0, -1);
        queue_frame(8'h00, 8'd0, 1'b0, -1);
        queue_frame(8'h42, 8'd0, 1'b1, -1);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h42);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h43);
        rx_pending.push_back(8'hFF);
        frame_beats += 6;
        wait_idle();
        queue_random_traffic(PHASE_BEATS);

        // Highest extremes, with equal control and status codes so that a match
        // must be classed as control. One frame runs to the largest length.
        set_regs(8'hFF, 8'hFF, 8'h5A, 8'h5A);
        queue_frame(8'h5A, 8'd3, 1'b0, -1);
        queue_frame(8'hA5, 8'd255, 1'b0, -1);
        wait_idle();
        queue_random_traffic(PHASE_BEATS);

        // Random register values with a modest length limit.
        set_regs(rand_byte(), 8'($urandom_range(4, 40)), rand_byte(), rand_byte());
        queue_random_traffic(PHASE_BEATS);

        // Back pressure: the sender streams full-length frames without gaps while
        // the receiver holds off, so both internal registers fill and the input
        // must stall.
        set_regs(START_BYTE_RST, 8'd16, CONTROL_CODE_RST, STATUS_CODE_RST);
        src_idle_on = 1'b0;
        repeat (4) queue_frame(rand_byte(), 8'd16, 1'b0, -1);
        pressure_go = 1'b1;
        wait_idle();
        src_idle_on = 1'b1;
        queue_random_traffic(PHASE_BEATS);

        if (awaited_results.size() != 0)
            flag_fault($sformatf("%0d expected results never arrived.",
                                 awaited_results.size()));

        $display("Run covered %0d input beats (%0d in frames) over %0d register writes,",
                 beats_taken, frame_beats, reg_writes);
        $display("%0d results: payload %0d control %0d status %0d other %0d",
                 results_seen, kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
        $display("bad sum %0d overlong %0d; %0d faults.",
                 kind_tally[4], kind_tally[5], fault_count);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xcfr_pkg.sv
rtl/xcfr_if.sv
rtl/xcfr_cfg_regs.sv
rtl/xcfr_parser.sv
rtl/xor_checked_frame_receiver.sv
tb/sv/xor_checked_frame_receiver_tb.sv
